[rtl/closed_polygon_subdivision_smoother_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands for the smoother RTL.
// ---------------------------------------------------------------------------
`ifndef CLOSED_POLYGON_SUBDIVISION_SMOOTHER_CORE_ASSERT_SVH
`define CLOSED_POLYGON_SUBDIVISION_SMOOTHER_CORE_ASSERT_SVH

// same-cycle implication
`define CPSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpss same-cycle check failed");

// next-cycle implication
`define CPSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpss next-cycle check failed");

`endif

[rtl/cpss_pkg.sv]
// ---------------------------------------------------------------------------
// cpss_pkg
// Widths, types and constants of the polygon subdivision smoother.
// ---------------------------------------------------------------------------
package cpss_pkg;

    localparam int COORD_WIDTH      = 20;
    localparam int FACTOR_FRAC_BITS = 12;
    localparam int FACTOR_WIDTH     = 16;

    localparam logic signed [FACTOR_WIDTH-1:0] FACTOR_RESET = FACTOR_WIDTH'(2048);

    // points left in a job: at most three triples of two points
    localparam int CNT_WIDTH = 3;
    localparam logic [CNT_WIDTH-1:0] CNT_NONE  = 3'd0;
    localparam logic [CNT_WIDTH-1:0] CNT_ONE   = 3'd1;
    localparam logic [CNT_WIDTH-1:0] CNT_TRI1  = 3'd2;
    localparam logic [CNT_WIDTH-1:0] CNT_TRI2  = 3'd4;
    localparam logic [CNT_WIDTH-1:0] CNT_TRI3  = 3'd6;

    localparam logic KIND_MID    = 1'b0;
    localparam logic KIND_CORNER = 1'b1;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_vtx;

    typedef struct packed {
        logic valid;
        logic kind;
        logic last;
        t_vtx a;
        t_vtx b;
        t_vtx c;
    } t_issue;

endpackage

[rtl/cpss_vtx_if.sv]
// ---------------------------------------------------------------------------
// cpss_vtx_if
// Vertex channel: valid/ready handshake with one polygon vertex.
// ---------------------------------------------------------------------------
interface cpss_vtx_if;
    logic            valid;
    logic            ready;
    cpss_pkg::t_coord in_x;
    cpss_pkg::t_coord in_y;
    logic            in_last;

    modport source (output valid, output in_x, output in_y, output in_last, input ready);
    modport sink   (input valid, input in_x, input in_y, input in_last, output ready);
endinterface

[rtl/cpss_pt_if.sv]
// ---------------------------------------------------------------------------
// cpss_pt_if
// Result point channel: valid/ready handshake with one output point.
// ---------------------------------------------------------------------------
interface cpss_pt_if;
    logic            valid;
    logic            ready;
    cpss_pkg::t_coord out_x;
    cpss_pkg::t_coord out_y;
    logic            out_kind;
    logic            out_last;

    modport source (output valid, output out_x, output out_y, output out_kind,
                    output out_last, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_kind,
                    input out_last, output ready);
endinterface

[rtl/cpss_ctrl.sv]
// ---------------------------------------------------------------------------
// cpss_ctrl
// Vertex history and job sequencer: builds up to three triples per vertex
// and issues their points one per cycle while the point datapath takes them.
// ---------------------------------------------------------------------------
`include "closed_polygon_subdivision_smoother_core_assert.svh"

module cpss_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cpss_vtx_if.sink         i_vtx,
    input  logic             i_take,
    output cpss_pkg::t_issue o_issue
);

    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_TWO  = 2'd2;

    cpss_pkg::t_vtx r_first, r_second, r_older, r_newer;
    logic [1:0]     r_seen, n_seen;

    cpss_pkg::t_vtx r_ja [3];
    cpss_pkg::t_vtx r_jb [3];
    cpss_pkg::t_vtx r_jc [3];
    cpss_pkg::t_vtx n_ja [3];
    cpss_pkg::t_vtx n_jb [3];
    cpss_pkg::t_vtx n_jc [3];

    logic [cpss_pkg::CNT_WIDTH-1:0] r_rem, n_cnt;
    logic                           r_phase;
    logic                           r_job_last;

    cpss_pkg::t_vtx v;
    logic           fire;
    logic           accept;

    assign v.x = i_vtx.in_x;
    assign v.y = i_vtx.in_y;

    assign fire        = (r_rem != cpss_pkg::CNT_NONE) && i_take;
    assign i_vtx.ready = (r_rem == cpss_pkg::CNT_NONE) ||
                         ((r_rem == cpss_pkg::CNT_ONE) && i_take);
    assign accept      = i_vtx.valid && i_vtx.ready;

    // build the job for the incoming vertex
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_ja[i] = v;
            n_jb[i] = v;
            n_jc[i] = v;
        end
        n_cnt  = cpss_pkg::CNT_NONE;
        n_seen = r_seen;
        if (!i_vtx.in_last) begin
            case (r_seen)
                SEEN_NONE: begin
                    n_seen = SEEN_ONE;
                end
                SEEN_ONE: begin
                    n_seen = SEEN_TWO;
                end
                default: begin
                    n_ja[0] = r_older;
                    n_jb[0] = r_newer;
                    n_cnt   = cpss_pkg::CNT_TRI1;
                end
            endcase
        end else begin
            n_seen = SEEN_NONE;
            case (r_seen)
                SEEN_NONE: begin
                    n_cnt = cpss_pkg::CNT_TRI1;
                end
                SEEN_ONE: begin
                    n_ja[0] = r_first;
                    n_jc[0] = r_first;
                    n_jb[1] = r_first;
                    n_cnt   = cpss_pkg::CNT_TRI2;
                end
                default: begin
                    n_ja[0] = r_older;
                    n_jb[0] = r_newer;
                    n_ja[1] = r_newer;
                    n_jc[1] = r_first;
                    n_jb[2] = r_first;
                    n_jc[2] = r_second;
                    n_cnt   = cpss_pkg::CNT_TRI3;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= SEEN_NONE;
            r_rem      <= cpss_pkg::CNT_NONE;
            r_phase    <= cpss_pkg::KIND_MID;
            r_job_last <= 1'b0;
        end else if (accept) begin
            r_seen     <= n_seen;
            r_rem      <= n_cnt;
            r_phase    <= cpss_pkg::KIND_MID;
            r_job_last <= i_vtx.in_last;
        end else if (fire) begin
            r_rem   <= r_rem - cpss_pkg::CNT_ONE;
            r_phase <= ~r_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < 3; i++) begin
                r_ja[i] <= n_ja[i];
                r_jb[i] <= n_jb[i];
                r_jc[i] <= n_jc[i];
            end
            if (r_seen == SEEN_NONE) begin
                r_first <= v;
            end
            if (r_seen == SEEN_ONE) begin
                r_second <= v;
            end
            r_older <= r_newer;
            r_newer <= v;
        end else if (fire && (r_phase == cpss_pkg::KIND_CORNER)) begin
            // advance to the next triple
            for (int i = 0; i < 2; i++) begin
                r_ja[i] <= r_ja[i+1];
                r_jb[i] <= r_jb[i+1];
                r_jc[i] <= r_jc[i+1];
            end
        end
    end

    assign o_issue.valid = (r_rem != cpss_pkg::CNT_NONE);
    assign o_issue.kind  = r_phase;
    assign o_issue.last  = r_job_last && (r_rem == cpss_pkg::CNT_ONE);
    assign o_issue.a     = r_ja[0];
    assign o_issue.b     = r_jb[0];
    assign o_issue.c     = r_jc[0];

    `CPSS_ASSERT_IMP(a_rem_bound, i_clk, i_rst_n, 1'b1, r_rem <= cpss_pkg::CNT_TRI3)
    `CPSS_ASSERT_IMP(a_busy_blocks, i_clk, i_rst_n, r_rem > cpss_pkg::CNT_ONE, !i_vtx.ready)
    `CPSS_ASSERT_NXT(a_last_restarts, i_clk, i_rst_n, accept && i_vtx.in_last,
                     (r_seen == SEEN_NONE) && (r_rem != cpss_pkg::CNT_NONE))
    `CPSS_ASSERT_NXT(a_triple_job, i_clk, i_rst_n,
                     accept && !i_vtx.in_last && (r_seen == SEEN_TWO),
                     (r_rem == cpss_pkg::CNT_TRI1) && (r_phase == cpss_pkg::KIND_MID))

endmodule

[rtl/cpss_point.sv]
// ---------------------------------------------------------------------------
// cpss_point
// Point datapath: edge midpoint or blended corner, saturated, into the
// result register.
// ---------------------------------------------------------------------------
module cpss_point (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  cpss_pkg::t_issue                            i_issue,
    input  logic signed [cpss_pkg::FACTOR_WIDTH-1:0]    i_factor,
    output logic                                        o_take,
    cpss_pt_if.source                                   o_pt
);

    localparam int CW = cpss_pkg::COORD_WIDTH;
    localparam int DW = CW + 2;
    localparam int PW = DW + cpss_pkg::FACTOR_WIDTH;
    localparam int SW = PW + 1;
    localparam int SH = cpss_pkg::FACTOR_FRAC_BITS + 2;
    localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_LO = SW'(-(64'sd1 <<< (CW - 1)));

    function automatic cpss_pkg::t_coord mid_coord(input cpss_pkg::t_coord a,
                                                   input cpss_pkg::t_coord b);
        logic signed [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        return s[CW:1];
    endfunction

    function automatic cpss_pkg::t_coord corner_coord(
        input cpss_pkg::t_coord                     a,
        input cpss_pkg::t_coord                     b,
        input cpss_pkg::t_coord                     c,
        input logic signed [cpss_pkg::FACTOR_WIDTH-1:0] t);
        logic signed [DW-1:0] d;
        logic signed [PW-1:0] p;
        logic signed [SW-1:0] s;
        d = DW'(a) - (DW'(b) <<< 1) + DW'(c);
        p = PW'(d) * PW'(t);
        s = SW'(p >>> SH) + SW'(b);
        if (s > SAT_HI) begin
            return SAT_HI[CW-1:0];
        end else if (s < SAT_LO) begin
            return SAT_LO[CW-1:0];
        end
        return s[CW-1:0];
    endfunction

    logic             r_valid;
    cpss_pkg::t_coord r_x, r_y;
    logic             r_kind, r_last;
    cpss_pkg::t_coord n_x, n_y;

    assign o_take = !r_valid || o_pt.ready;

    always_comb begin
        if (i_issue.kind == cpss_pkg::KIND_CORNER) begin
            n_x = corner_coord(i_issue.a.x, i_issue.b.x, i_issue.c.x, i_factor);
            n_y = corner_coord(i_issue.a.y, i_issue.b.y, i_issue.c.y, i_factor);
        end else begin
            n_x = mid_coord(i_issue.a.x, i_issue.b.x);
            n_y = mid_coord(i_issue.a.y, i_issue.b.y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_issue.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_issue.valid) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_kind <= i_issue.kind;
            r_last <= i_issue.last;
        end
    end

    assign o_pt.valid    = r_valid;
    assign o_pt.out_x    = r_x;
    assign o_pt.out_y    = r_y;
    assign o_pt.out_kind = r_kind;
    assign o_pt.out_last = r_last;

endmodule

[rtl/closed_polygon_subdivision_smoother_core.sv]
// ---------------------------------------------------------------------------
// closed_polygon_subdivision_smoother_core
// One corner-cutting subdivision pass over a closed polygon.
// ---------------------------------------------------------------------------
//   i_vtx carries the polygon vertices in order; in_last marks the final one.
//   o_pt returns, per vertex triple, an edge midpoint (out_kind 0) followed
//   by the blended corner (out_kind 1); out_last flags the final point.
//   i_cfg_wr_en/i_cfg_wr_data write the signed Q4.12 smoothing factor;
//   write it only while no transaction is in flight.
//   The first point of a vertex is issued from the job registers, then
//   captured in the result register, from which o_pt presents it.
//   The result register passes one point per cycle while o_pt is ready;
//   a vertex yields no points if it is the first or second of a polygon,
//   two for the others, and two, four or six for the final vertex.
//   The next vertex is taken in the cycle the previous job issues its last
//   point, while the result register may still hold an untaken point.
//   A stall on o_pt holds the result register and then blocks i_vtx.
//   Reset clears the vertex count, empties the pipeline and sets the
//   factor to 0.5.
// ---------------------------------------------------------------------------
module closed_polygon_subdivision_smoother_core (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_wr_en,
    input  logic signed [cpss_pkg::FACTOR_WIDTH-1:0] i_cfg_wr_data,
    cpss_vtx_if.sink                                 i_vtx,
    cpss_pt_if.source                                o_pt
);

    logic signed [cpss_pkg::FACTOR_WIDTH-1:0] r_factor;
    cpss_pkg::t_issue                         issue;
    logic                                     take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= cpss_pkg::FACTOR_RESET;
        end else if (i_cfg_wr_en) begin
            r_factor <= i_cfg_wr_data;
        end
    end

    cpss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (i_vtx),
        .i_take  (take),
        .o_issue (issue)
    );

    cpss_point u_point (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_issue  (issue),
        .i_factor (r_factor),
        .o_take   (take),
        .o_pt     (o_pt)
    );

endmodule
